// File: design/ecal_pkg.sv
package ecal_pkg;

    // Defaults and fixed widths
    localparam int unsigned TIME_WIDTH_DEF = 40;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned DIV_DIG_W      = 8;    // quotient bits per divider digit
    localparam int unsigned SOD_W          = 17;   // seconds of day, below 86400
    localparam int unsigned ERA_W          = 18;   // day of era, below 146097
    localparam int unsigned SREM_W         = 12;   // seconds within the hour
    localparam int unsigned YOE_W          = 9;    // year of era, 0..399
    localparam int unsigned MP_NUM_W       = 11;   // 5 * doy + 2
    localparam int unsigned CIVIL_SHIFT_W  = 21;

    // Calendar constants
    localparam int unsigned DAY_SECS       = 86400;
    localparam int unsigned DAY_SECS_M1    = 86399;
    localparam int unsigned HOUR_SECS      = 3600;
    localparam int unsigned MIN_SECS       = 60;
    localparam int unsigned ERA_DAYS       = 146097;
    localparam int unsigned ERA_DAYS_M1    = 146096;
    localparam int unsigned CIVIL_SHIFT    = 719468;
    localparam int unsigned CYC4_DAYS      = 1460;
    localparam int unsigned CYC100_DAYS    = 36524;
    localparam int unsigned YEAR_DAYS      = 365;
    localparam int unsigned ERA_YEARS      = 400;
    localparam int unsigned CENT_YEARS     = 100;
    localparam int unsigned MONTH5_DAYS    = 153;
    localparam int unsigned WEEK_DAYS      = 7;
    localparam int unsigned WDAY_SHIFT     = 3;    // weekday of day-of-era zero, offset
    localparam int unsigned YEARS_1900     = 1900;
    localparam int unsigned MP_JANUARY     = 10;   // March-based month index of January
    localparam int unsigned MP_TO_MON      = 2;
    localparam int unsigned MON_MARCH      = 2;

    // Reciprocal multipliers: floor(n / d) = (n * M) >> S, exact for n < 2^N
    // when S = N + clog2(d) and M = ceil(2^S / d)
    localparam int unsigned RCP_M_W  = 21;

    localparam int unsigned RCP_S_CYC4   = ERA_W + $clog2(CYC4_DAYS);
    localparam logic [RCP_M_W-1:0] RCP_M_CYC4 =
        RCP_M_W'(((64'd1 << RCP_S_CYC4) + 64'(CYC4_DAYS) - 64'd1) / 64'(CYC4_DAYS));

    localparam int unsigned RCP_S_CYC100 = ERA_W + $clog2(CYC100_DAYS);
    localparam logic [RCP_M_W-1:0] RCP_M_CYC100 =
        RCP_M_W'(((64'd1 << RCP_S_CYC100) + 64'(CYC100_DAYS) - 64'd1) / 64'(CYC100_DAYS));

    localparam int unsigned RCP_S_WEEK   = ERA_W + $clog2(WEEK_DAYS);
    localparam logic [RCP_M_W-1:0] RCP_M_WEEK =
        RCP_M_W'(((64'd1 << RCP_S_WEEK) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    localparam int unsigned RCP_S_HOUR   = SOD_W + $clog2(HOUR_SECS);
    localparam logic [RCP_M_W-1:0] RCP_M_HOUR =
        RCP_M_W'(((64'd1 << RCP_S_HOUR) + 64'(HOUR_SECS) - 64'd1) / 64'(HOUR_SECS));

    localparam int unsigned RCP_S_YEAR   = ERA_W + $clog2(YEAR_DAYS);
    localparam logic [RCP_M_W-1:0] RCP_M_YEAR =
        RCP_M_W'(((64'd1 << RCP_S_YEAR) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

    localparam int unsigned RCP_S_MIN    = SREM_W + $clog2(MIN_SECS);
    localparam logic [RCP_M_W-1:0] RCP_M_MIN =
        RCP_M_W'(((64'd1 << RCP_S_MIN) + 64'(MIN_SECS) - 64'd1) / 64'(MIN_SECS));

    localparam int unsigned RCP_S_CENT   = YOE_W + $clog2(CENT_YEARS);
    localparam logic [RCP_M_W-1:0] RCP_M_CENT =
        RCP_M_W'(((64'd1 << RCP_S_CENT) + 64'(CENT_YEARS) - 64'd1) / 64'(CENT_YEARS));

    localparam int unsigned RCP_S_MONTH5 = MP_NUM_W + $clog2(MONTH5_DAYS);
    localparam logic [RCP_M_W-1:0] RCP_M_MONTH5 =
        RCP_M_W'(((64'd1 << RCP_S_MONTH5) + 64'(MONTH5_DAYS) - 64'd1) / 64'(MONTH5_DAYS));

    // Time of day fields, grouped once they are final
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } clock_t;

    // Multiply by reciprocal and shift
    function automatic logic [19:0] rcp_div(
        input logic [19:0]        num,
        input logic [RCP_M_W-1:0] mul,
        input int unsigned        shift
    );
        logic [40:0] prod;
        prod = 41'(num) * 41'(mul);
        return 20'(prod >> shift);
    endfunction

    // First day of a March-based month within the March-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        unique case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // Days before a January-based month in a common year
    function automatic logic [8:0] month_cum(input logic [3:0] mon);
        logic [8:0] res;
        unique case (mon)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd59;
            4'd3:    res = 9'd90;
            4'd4:    res = 9'd120;
            4'd5:    res = 9'd151;
            4'd6:    res = 9'd181;
            4'd7:    res = 9'd212;
            4'd8:    res = 9'd243;
            4'd9:    res = 9'd273;
            4'd10:   res = 9'd304;
            4'd11:   res = 9'd334;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

    // Leap rule on the year taken modulo 400 (0..400)
    function automatic logic leap400(input logic [8:0] yy);
        return (yy[1:0] == 2'b00) && (yy != 9'd100) && (yy != 9'd200) && (yy != 9'd300);
    endfunction

endpackage

// File: design/ecal_cdiv.sv
module ecal_cdiv #(
    parameter int unsigned      NUM_W  = ecal_pkg::TIME_WIDTH_DEF - 1,
    parameter int unsigned      DEN_W  = ecal_pkg::SOD_W,
    parameter logic [DEN_W-1:0] DEN    = DEN_W'(ecal_pkg::DAY_SECS),
    parameter int unsigned      SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    // Long division a digit at a time, two stages per digit: reciprocal quotient, then remainder
    localparam int unsigned     DIG_W = ecal_pkg::DIV_DIG_W;
    localparam int unsigned     NDIG  = (NUM_W + DIG_W - 1) / DIG_W;
    localparam int unsigned     PAD_W = NDIG * DIG_W;
    localparam int unsigned     X_W   = DEN_W + DIG_W;
    localparam int unsigned     SH    = X_W + DEN_W;
    localparam longint unsigned M_VAL = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam int unsigned     M_W   = $clog2(M_VAL + 64'd1);
    localparam logic [M_W-1:0]  RCP_M = M_W'(M_VAL);
    localparam int unsigned     P_W   = X_W + M_W;

    // Digit taps; index 0 is the input, index s+1 the output of digit s
    logic              vld  [NDIG+1];
    logic [PAD_W-1:0]  word [NDIG+1];
    logic [DEN_W-1:0]  rmd  [NDIG+1];
    logic [SIDE_W-1:0] side [NDIG+1];

    assign vld[0]  = in_valid;
    assign word[0] = PAD_W'(in_num);
    assign rmd[0]  = '0;
    assign side[0] = in_side;

    // The word shifts numerator digits out at the top and quotient digits in at the bottom
    for (genvar s = 0; s < NDIG; s++)
    begin : g_digit
        logic [X_W-1:0]    part;
        logic [P_W-1:0]    prod;
        logic [DIG_W-1:0]  q_next;
        logic [DEN_W-1:0]  rmd_next;
        logic [PAD_W-1:0]  word_next;
        logic              vld_a_reg;
        logic              vld_b_reg;
        logic [X_W-1:0]    part_reg;
        logic [DIG_W-1:0]  q_reg;
        logic [PAD_W-1:0]  word_a_reg;
        logic [PAD_W-1:0]  word_b_reg;
        logic [DEN_W-1:0]  rmd_reg;
        logic [SIDE_W-1:0] side_a_reg;
        logic [SIDE_W-1:0] side_b_reg;

        // Partial dividend below DEN * 2^DIG_W, so the quotient digit is exact
        always_comb
        begin
            part   = {rmd[s], word[s][PAD_W-1 -: DIG_W]};
            prod   = P_W'(part) * P_W'(RCP_M);
            q_next = DIG_W'(prod >> SH);
        end

        // Remainder of the digit, quotient digit shifted in
        always_comb
        begin
            rmd_next  = DEN_W'(part_reg - X_W'(q_reg) * X_W'(DEN));
            word_next = {word_a_reg[PAD_W-DIG_W-1:0], q_reg};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_a_reg <= 1'b0;
                vld_b_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_a_reg <= vld[s];
                vld_b_reg <= vld_a_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                part_reg   <= part;
                q_reg      <= q_next;
                word_a_reg <= word[s];
                side_a_reg <= side[s];
                word_b_reg <= word_next;
                rmd_reg    <= rmd_next;
                side_b_reg <= side_a_reg;
            end
        end

        assign vld[s+1]  = vld_b_reg;
        assign word[s+1] = word_b_reg;
        assign rmd[s+1]  = rmd_reg;
        assign side[s+1] = side_b_reg;
    end

    assign out_valid = vld[NDIG];
    assign out_quo   = word[NDIG][NUM_W-1:0];
    assign out_rem   = rmd[NDIG];
    assign out_side  = side[NDIG];

endmodule

// File: design/ecal_front.sv
module ecal_front #(
    parameter int unsigned TIME_WIDTH = ecal_pkg::TIME_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [TIME_WIDTH-1:0]        epoch_seconds,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [TIME_WIDTH-17:0]       out_days,
    output logic [ecal_pkg::SOD_W-1:0]   out_sod
);

    localparam int unsigned NUM_W = TIME_WIDTH - 1;
    localparam int unsigned DAY_W = TIME_WIDTH - 16;

    logic                       en;
    logic                       neg;
    logic [NUM_W-1:0]           mag;
    logic                       div_valid;
    logic [NUM_W-1:0]           div_quo;
    logic [ecal_pkg::SOD_W-1:0] div_rem;
    logic                       div_neg;
    logic [DAY_W-1:0]           days_pos;

    // Negative times divide the one's complement, then fold back to a floor
    assign neg = epoch_seconds[TIME_WIDTH-1];
    assign mag = neg ? ~epoch_seconds[NUM_W-1:0] : epoch_seconds[NUM_W-1:0];

    // Pipeline moves whenever its last stage is free or being drained
    assign en       = !div_valid || out_ready;
    assign in_ready = en;

    ecal_cdiv #(
        .NUM_W  (NUM_W),
        .DEN_W  (ecal_pkg::SOD_W),
        .DEN    (ecal_pkg::SOD_W'(ecal_pkg::DAY_SECS)),
        .SIDE_W (1)
    ) u_day_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_num    (mag),
        .in_side   (neg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_rem   (div_rem),
        .out_side  (div_neg)
    );

    // floor(-(u+1)/d) = ~q, seconds of day mirrored
    assign days_pos  = {1'b0, div_quo[DAY_W-2:0]};
    assign out_valid = div_valid;
    assign out_days  = div_neg ? ~days_pos : days_pos;
    assign out_sod   = div_neg ? ecal_pkg::SOD_W'(ecal_pkg::DAY_SECS_M1) - div_rem : div_rem;

endmodule

// File: design/ecal_fifo.sv
module ecal_fifo #(
    parameter int unsigned DATA_W = ecal_pkg::TIME_WIDTH_DEF - 16 + ecal_pkg::SOD_W,
    parameter int unsigned DEPTH  = ecal_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: design/ecal_back.sv
module ecal_back #(
    parameter int unsigned TIME_WIDTH = ecal_pkg::TIME_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [TIME_WIDTH-17:0]     in_days,
    input  logic [ecal_pkg::SOD_W-1:0] in_sod,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [15:0]                years_since_1900,
    output logic [3:0]                 month_index,
    output logic [4:0]                 day_of_month,
    output logic [4:0]                 hour_of_day,
    output logic [5:0]                 minute_of_hour,
    output logic [5:0]                 second_of_minute,
    output logic [2:0]                 weekday,
    output logic [8:0]                 day_of_year
);

    localparam int unsigned DAY_W  = TIME_WIDTH - 16;
    localparam int unsigned EXT_W  =
        ((DAY_W > ecal_pkg::CIVIL_SHIFT_W) ? DAY_W : ecal_pkg::CIVIL_SHIFT_W) + 1;
    localparam int unsigned NUM_W  = EXT_W - 1;
    localparam int unsigned SOD_W  = ecal_pkg::SOD_W;
    localparam int unsigned ERA_W  = ecal_pkg::ERA_W;
    localparam int unsigned STAGES = 9;

    logic                en;
    logic [STAGES-1:0]   vld_reg;
    logic [EXT_W-1:0]    shifted;
    logic                neg;
    logic [NUM_W-1:0]    mag;
    logic                div_valid;
    logic [NUM_W-1:0]    div_quo;
    logic [ERA_W-1:0]    div_rem;
    logic [SOD_W:0]      div_side;

    // Day of era, era (low bits), seconds of day
    logic [15:0]         p1_era_reg;
    logic [ERA_W-1:0]    p1_doe_reg;
    logic [SOD_W-1:0]    p1_sod_reg;
    // Reciprocal quotients
    logic [6:0]          p2_q1_reg;
    logic [2:0]          p2_q2_reg;
    logic                p2_q3_reg;
    logic [14:0]         p2_w7_reg;
    logic [4:0]          p2_hr_reg;
    logic [15:0]         p2_e400_reg;
    logic [ERA_W-1:0]    p2_doe_reg;
    logic [SOD_W-1:0]    p2_sod_reg;
    // Leap-corrected day count, weekday, seconds within hour
    logic [ERA_W-1:0]    p3_t_reg;
    logic [2:0]          p3_wday_reg;
    logic [11:0]         p3_srem_reg;
    logic [4:0]          p3_hr_reg;
    logic [15:0]         p3_e400_reg;
    logic [ERA_W-1:0]    p3_doe_reg;
    // Year of era, minute
    logic [8:0]          p4_yoe_reg;
    logic [5:0]          p4_mn_reg;
    logic [11:0]         p4_srem_reg;
    logic [4:0]          p4_hr_reg;
    logic [2:0]          p4_wday_reg;
    logic [15:0]         p4_e400_reg;
    logic [ERA_W-1:0]    p4_doe_reg;
    // Centuries, finished clock fields
    logic [1:0]          p5_c100_reg;
    ecal_pkg::clock_t    p5_clock_reg;
    logic [8:0]          p5_yoe_reg;
    logic [15:0]         p5_e400_reg;
    logic [ERA_W-1:0]    p5_doe_reg;
    // Day of March-based year
    logic [8:0]          p6_doy_reg;
    logic [8:0]          p6_yoe_reg;
    logic [15:0]         p6_e400_reg;
    ecal_pkg::clock_t    p6_clock_reg;
    // March-based month
    logic [3:0]          p7_mp_reg;
    logic [8:0]          p7_doy_reg;
    logic [8:0]          p7_yoe_reg;
    logic [15:0]         p7_e400_reg;
    ecal_pkg::clock_t    p7_clock_reg;
    logic                p7_jan_feb;
    logic [8:0]          p7_yy;
    // Civil date
    logic [4:0]          p8_day_reg;
    logic [3:0]          p8_mon_reg;
    logic                p8_leap_reg;
    logic [15:0]         p8_year_reg;
    ecal_pkg::clock_t    p8_clock_reg;
    // Output word
    logic [15:0]         out_year_reg;
    logic [3:0]          out_mon_reg;
    logic [4:0]          out_day_reg;
    logic [8:0]          out_yday_reg;
    ecal_pkg::clock_t    out_clock_reg;

    // Shift to a March 0000 origin and split sign for the era divider
    assign shifted = EXT_W'($signed(in_days)) + EXT_W'(ecal_pkg::CIVIL_SHIFT);
    assign neg     = shifted[EXT_W-1];
    assign mag     = neg ? ~shifted[NUM_W-1:0] : shifted[NUM_W-1:0];

    assign en       = !vld_reg[STAGES-1] || out_ready;
    assign in_ready = en;

    ecal_cdiv #(
        .NUM_W  (NUM_W),
        .DEN_W  (ERA_W),
        .DEN    (ERA_W'(ecal_pkg::ERA_DAYS)),
        .SIDE_W (SOD_W + 1)
    ) u_era_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_num    (mag),
        .in_side   ({neg, in_sod}),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_rem   (div_rem),
        .out_side  (div_side)
    );

    // Valid flags of the civil stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], div_valid};
        end
    end

    // Month and leap terms of the date stage
    assign p7_jan_feb = (p7_mp_reg >= 4'(ecal_pkg::MP_JANUARY));
    assign p7_yy      = p7_yoe_reg + 9'(p7_jan_feb);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // floor fold of era, day of era
            p1_era_reg <= div_side[SOD_W] ? ~div_quo[15:0] : div_quo[15:0];
            p1_doe_reg <= div_side[SOD_W] ? ERA_W'(ecal_pkg::ERA_DAYS_M1) - div_rem : div_rem;
            p1_sod_reg <= div_side[SOD_W-1:0];

            // quotients by constants
            p2_q1_reg   <= 7'(ecal_pkg::rcp_div(20'(p1_doe_reg),
                              ecal_pkg::RCP_M_CYC4, ecal_pkg::RCP_S_CYC4));
            p2_q2_reg   <= 3'(ecal_pkg::rcp_div(20'(p1_doe_reg),
                              ecal_pkg::RCP_M_CYC100, ecal_pkg::RCP_S_CYC100));
            p2_q3_reg   <= (p1_doe_reg == ERA_W'(ecal_pkg::ERA_DAYS_M1));
            p2_w7_reg   <= 15'(ecal_pkg::rcp_div(20'(p1_doe_reg) + 20'(ecal_pkg::WDAY_SHIFT),
                              ecal_pkg::RCP_M_WEEK, ecal_pkg::RCP_S_WEEK));
            p2_hr_reg   <= 5'(ecal_pkg::rcp_div(20'(p1_sod_reg),
                              ecal_pkg::RCP_M_HOUR, ecal_pkg::RCP_S_HOUR));
            p2_e400_reg <= p1_era_reg * 16'(ecal_pkg::ERA_YEARS);
            p2_doe_reg  <= p1_doe_reg;
            p2_sod_reg  <= p1_sod_reg;

            // remainders and leap-day correction
            p3_t_reg    <= p2_doe_reg - ERA_W'(p2_q1_reg) + ERA_W'(p2_q2_reg)
                           - ERA_W'(p2_q3_reg);
            p3_wday_reg <= 3'(20'(p2_doe_reg) + 20'(ecal_pkg::WDAY_SHIFT)
                           - 20'(p2_w7_reg) * 20'(ecal_pkg::WEEK_DAYS));
            p3_srem_reg <= 12'(p2_sod_reg - SOD_W'(p2_hr_reg) * SOD_W'(ecal_pkg::HOUR_SECS));
            p3_hr_reg   <= p2_hr_reg;
            p3_e400_reg <= p2_e400_reg;
            p3_doe_reg  <= p2_doe_reg;

            // year of era, minute
            p4_yoe_reg  <= 9'(ecal_pkg::rcp_div(20'(p3_t_reg),
                              ecal_pkg::RCP_M_YEAR, ecal_pkg::RCP_S_YEAR));
            p4_mn_reg   <= 6'(ecal_pkg::rcp_div(20'(p3_srem_reg),
                              ecal_pkg::RCP_M_MIN, ecal_pkg::RCP_S_MIN));
            p4_srem_reg <= p3_srem_reg;
            p4_hr_reg   <= p3_hr_reg;
            p4_wday_reg <= p3_wday_reg;
            p4_e400_reg <= p3_e400_reg;
            p4_doe_reg  <= p3_doe_reg;

            // centuries, second
            p5_c100_reg          <= 2'(ecal_pkg::rcp_div(20'(p4_yoe_reg),
                                       ecal_pkg::RCP_M_CENT, ecal_pkg::RCP_S_CENT));
            p5_clock_reg.hour    <= p4_hr_reg;
            p5_clock_reg.minute  <= p4_mn_reg;
            p5_clock_reg.second  <= 6'(p4_srem_reg
                                       - 12'(p4_mn_reg) * 12'(ecal_pkg::MIN_SECS));
            p5_clock_reg.weekday <= p4_wday_reg;
            p5_yoe_reg           <= p4_yoe_reg;
            p5_e400_reg          <= p4_e400_reg;
            p5_doe_reg           <= p4_doe_reg;

            // day of March-based year
            p6_doy_reg   <= 9'(p5_doe_reg - (ERA_W'(p5_yoe_reg) * ERA_W'(ecal_pkg::YEAR_DAYS)
                            + ERA_W'(p5_yoe_reg[8:2]) - ERA_W'(p5_c100_reg)));
            p6_yoe_reg   <= p5_yoe_reg;
            p6_e400_reg  <= p5_e400_reg;
            p6_clock_reg <= p5_clock_reg;

            // March-based month
            p7_mp_reg    <= 4'(ecal_pkg::rcp_div(20'(p6_doy_reg) * 20'd5 + 20'd2,
                              ecal_pkg::RCP_M_MONTH5, ecal_pkg::RCP_S_MONTH5));
            p7_doy_reg   <= p6_doy_reg;
            p7_yoe_reg   <= p6_yoe_reg;
            p7_e400_reg  <= p6_e400_reg;
            p7_clock_reg <= p6_clock_reg;

            // civil date; Jan and Feb belong to the next year
            p8_day_reg   <= 5'(p7_doy_reg - ecal_pkg::month_start(p7_mp_reg) + 9'd1);
            p8_mon_reg   <= p7_jan_feb ? p7_mp_reg - 4'(ecal_pkg::MP_JANUARY)
                                       : p7_mp_reg + 4'(ecal_pkg::MP_TO_MON);
            p8_leap_reg  <= ecal_pkg::leap400(p7_yy);
            p8_year_reg  <= p7_e400_reg + 16'(p7_yy) - 16'(ecal_pkg::YEARS_1900);
            p8_clock_reg <= p7_clock_reg;

            // output word with day of year
            out_year_reg  <= p8_year_reg;
            out_mon_reg   <= p8_mon_reg;
            out_day_reg   <= p8_day_reg;
            out_yday_reg  <= ecal_pkg::month_cum(p8_mon_reg)
                             + 9'(p8_leap_reg && (p8_mon_reg >= 4'(ecal_pkg::MON_MARCH)))
                             + 9'(p8_day_reg) - 9'd1;
            out_clock_reg <= p8_clock_reg;
        end
    end

    assign out_valid        = vld_reg[STAGES-1];
    assign years_since_1900 = out_year_reg;
    assign month_index      = out_mon_reg;
    assign day_of_month     = out_day_reg;
    assign hour_of_day      = out_clock_reg.hour;
    assign minute_of_hour   = out_clock_reg.minute;
    assign second_of_minute = out_clock_reg.second;
    assign weekday          = out_clock_reg.weekday;
    assign day_of_year      = out_yday_reg;

endmodule

// File: design/epoch_seconds_to_calendar.sv
// Datapath: divider by 86400, the queue, divider by 146097 (two stages per 8-bit digit) and
// nine calendar stages.
// Throughput: one word per cycle while out_ready is high; every stage is pipelined and the
// queue decouples the halves.
// Reset: rst_n clears valid flags and queue pointers asynchronously; no clearing pass,
// a word can be accepted as soon as reset is released.
module epoch_seconds_to_calendar #(
    parameter int unsigned TIME_WIDTH = ecal_pkg::TIME_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [TIME_WIDTH-1:0] epoch_seconds,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           years_since_1900,
    output logic [3:0]                   month_index,
    output logic [4:0]                   day_of_month,
    output logic [4:0]                   hour_of_day,
    output logic [5:0]                   minute_of_hour,
    output logic [5:0]                   second_of_minute,
    output logic [2:0]                   weekday,
    output logic [8:0]                   day_of_year
);

    localparam int unsigned DAY_W = TIME_WIDTH - 16;
    localparam int unsigned Q_W   = DAY_W + ecal_pkg::SOD_W;

    logic                       fr_valid, fr_ready;
    logic [DAY_W-1:0]           fr_days;
    logic [ecal_pkg::SOD_W-1:0] fr_sod;
    logic                       bk_valid, bk_ready;
    logic [Q_W-1:0]             bk_data;

    // Day split
    ecal_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .epoch_seconds (epoch_seconds),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_days      (fr_days),
        .out_sod       (fr_sod)
    );

    // Decoupling queue
    ecal_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (ecal_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_days, fr_sod}),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    // Civil date and clock fields
    ecal_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (bk_valid),
        .in_ready         (bk_ready),
        .in_days          (bk_data[Q_W-1:ecal_pkg::SOD_W]),
        .in_sod           (bk_data[ecal_pkg::SOD_W-1:0]),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .day_of_year      (day_of_year)
    );

endmodule
